// File: rtl/core/esd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esd_pkg
// shared types and constants of the escape sequence decoder
// ----------------------------------------------------------------------------
package esd_pkg;

    // decoder mode
    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_ESC   = 2'd1,
        MODE_OCT   = 2'd2,
        MODE_HEX   = 2'd3
    } esd_mode_t;

    localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;
    localparam logic [1:0] HEX_MAX_DIGITS = 2'd2;

    // result queue
    localparam int ESD_FIFO_DEPTH = 4;
    localparam int ESD_FIFO_PW    = $clog2(ESD_FIFO_DEPTH);
    localparam int ESD_FIFO_CW    = $clog2(ESD_FIFO_DEPTH + 1);

    typedef struct packed {
        esd_mode_t  mode;
        logic [1:0] digit_count;
        logic [7:0] accum_value;
    } esd_state_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       run_last;
        logic       string_done;
    } esd_result_t;

    typedef struct packed {
        logic                   room;
        logic [ESD_FIFO_CW-1:0] level;
    } esd_fifo_status_t;

endpackage

// File: rtl/core/esd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esd_decode
// next-state and result logic for one raw byte, up to two results
// ----------------------------------------------------------------------------
module esd_decode import esd_pkg::*; (
    input  esd_state_t  state_i,
    input  logic [7:0]  byte_i,
    input  logic        end_i,
    output esd_state_t  state_o,
    output logic [1:0]  res_n_o,
    output esd_result_t res0_o,
    output esd_result_t res1_o
);

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_A         = 8'h61;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_V         = 8'h76;
    localparam logic [7:0] CH_X         = 8'h78;

    logic       is_oct;
    logic       is_hex;
    logic [3:0] hex_val;
    logic [7:0] hex_tmp;
    logic       run_plain;
    logic       first_emit;
    logic [7:0] first_val;
    logic       plain_emit;
    logic       end_emit;
    logic [7:0] end_val;
    logic [1:0] emit_cnt;
    esd_state_t st;

    assign is_oct = (byte_i >= 8'h30) && (byte_i <= 8'h37);

    always_comb begin
        is_hex  = 1'b1;
        hex_tmp = byte_i - 8'h30;
        if ((byte_i >= 8'h30) && (byte_i <= 8'h39)) begin
            hex_tmp = byte_i - 8'h30;
        end else if ((byte_i >= 8'h61) && (byte_i <= 8'h66)) begin
            hex_tmp = byte_i - 8'h57;
        end else if ((byte_i >= 8'h41) && (byte_i <= 8'h46)) begin
            hex_tmp = byte_i - 8'h37;
        end else begin
            is_hex = 1'b0;
        end
        hex_val = hex_tmp[3:0];
    end

    always_comb begin
        st         = state_i;
        run_plain  = 1'b0;
        first_emit = 1'b0;
        first_val  = state_i.accum_value;
        plain_emit = 1'b0;
        end_emit   = 1'b0;

        unique case (state_i.mode)
            MODE_PLAIN: begin
                run_plain = 1'b1;
            end
            MODE_ESC: begin
                st.mode    = MODE_PLAIN;
                first_emit = 1'b1;
                unique case (byte_i)
                    CH_BACKSLASH: first_val = 8'h5C;
                    CH_A:         first_val = 8'h07;
                    CH_B:         first_val = 8'h08;
                    CH_N:         first_val = 8'h0A;
                    CH_R:         first_val = 8'h0D;
                    CH_T:         first_val = 8'h09;
                    CH_V:         first_val = 8'h0B;
                    CH_X: begin
                        first_emit     = 1'b0;
                        st.mode        = MODE_HEX;
                        st.digit_count = 2'd0;
                        st.accum_value = 8'd0;
                    end
                    default: begin
                        first_emit = 1'b0;
                        if (is_oct) begin
                            st.mode        = MODE_OCT;
                            st.digit_count = 2'd1;
                            st.accum_value = {5'd0, byte_i[2:0]};
                        end
                    end
                endcase
            end
            MODE_OCT: begin
                if (is_oct) begin
                    st.accum_value = {state_i.accum_value[4:0], byte_i[2:0]};
                    st.digit_count = state_i.digit_count + 2'd1;
                    if (st.digit_count >= OCT_MAX_DIGITS) begin
                        first_emit = 1'b1;
                        first_val  = st.accum_value;
                        st.mode    = MODE_PLAIN;
                    end
                end else begin
                    first_emit = 1'b1;
                    st.mode    = MODE_PLAIN;
                    run_plain  = 1'b1;
                end
            end
            MODE_HEX: begin
                if (is_hex) begin
                    st.accum_value = {state_i.accum_value[3:0], hex_val};
                    st.digit_count = state_i.digit_count + 2'd1;
                    if (st.digit_count >= HEX_MAX_DIGITS) begin
                        first_emit = 1'b1;
                        first_val  = st.accum_value;
                        st.mode    = MODE_PLAIN;
                    end
                end else begin
                    first_emit = (state_i.digit_count != 2'd0);
                    st.mode    = MODE_PLAIN;
                    run_plain  = 1'b1;
                end
            end
            default: begin
                run_plain = 1'b1;
            end
        endcase

        if (run_plain) begin
            if (byte_i == CH_BACKSLASH) begin
                st.mode        = MODE_ESC;
                st.digit_count = 2'd0;
                st.accum_value = 8'd0;
            end else begin
                plain_emit = 1'b1;
            end
        end

        // open numeric escape closed by the end of the string
        end_val = st.accum_value;
        if (end_i) begin
            end_emit = ((st.mode == MODE_OCT) || (st.mode == MODE_HEX))
                       && (st.digit_count != 2'd0);
            st.mode        = MODE_PLAIN;
            st.digit_count = 2'd0;
            st.accum_value = 8'd0;
        end
    end

    always_comb begin
        emit_cnt = {1'b0, first_emit} + {1'b0, plain_emit} + {1'b0, end_emit};
        res_n_o  = ((emit_cnt == 2'd0) && end_i) ? 2'd1 : emit_cnt;

        res0_o.has_byte    = first_emit || plain_emit || end_emit;
        res0_o.out_byte    = first_emit ? first_val :
                             plain_emit ? byte_i :
                             end_emit   ? end_val : 8'd0;
        res0_o.run_last    = (res_n_o == 2'd1);
        res0_o.string_done = end_i && (res_n_o == 2'd1);

        res1_o.has_byte    = 1'b1;
        res1_o.out_byte    = (first_emit && plain_emit) ? byte_i : end_val;
        res1_o.run_last    = 1'b1;
        res1_o.string_done = end_i;
    end

    assign state_o = st;

endmodule

// File: rtl/core/esd_result_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esd_result_fifo
// short result queue, takes up to two results a cycle, gives one while out_ready is high
// ----------------------------------------------------------------------------
module esd_result_fifo import esd_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [1:0]       push_n,
    input  esd_result_t      push0,
    input  esd_result_t      push1,
    output logic             out_valid,
    input  logic             out_ready,
    output esd_result_t      out_head,
    output esd_fifo_status_t status
);

    esd_result_t            mem [ESD_FIFO_DEPTH];
    logic [ESD_FIFO_PW-1:0] wr_ptr_reg;
    logic [ESD_FIFO_PW-1:0] wr_ptr_next;
    logic [ESD_FIFO_PW-1:0] rd_ptr_reg;
    logic [ESD_FIFO_PW-1:0] rd_ptr_next;
    logic [ESD_FIFO_CW-1:0] count_reg;
    logic [ESD_FIFO_CW-1:0] count_next;
    logic                   pop;

    assign out_valid    = (count_reg != '0);
    assign out_head     = mem[rd_ptr_reg];
    assign pop          = out_valid && out_ready;
    assign status.level = count_reg;
    assign status.room  = (count_reg <= ESD_FIFO_CW'(ESD_FIFO_DEPTH - 2));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + ESD_FIFO_PW'(push_n);
        rd_ptr_next = rd_ptr_reg + ESD_FIFO_PW'(pop);
        count_next  = count_reg + ESD_FIFO_CW'(push_n) - ESD_FIFO_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_n == 2'd2) begin
            mem[wr_ptr_reg + ESD_FIFO_PW'(1)] <= push1;
        end
    end

endmodule

// File: rtl/core/escape_sequence_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_sequence_decoder_unit
// streaming decoder for c-style backslash escapes in a byte string
// ----------------------------------------------------------------------------
//  channel  dir  ports                        carries
//  s_       in   tvalid tready tdata tlast    raw byte, end of string
//  m_       out  tvalid tready tdata tuser    decoded byte, has_byte/run_last,
//                tlast                        end of string
//
//  one raw byte is taken per cycle while s_tready is high; a taken byte is
//  decoded from the input register into a four-entry result queue
//  a byte gives zero, one or two results; the queue drains one per cycle
//  while m_tready is high, so a byte with two results takes two transfers
//  input stalls only while a staged byte waits for room for two results
//  aresetn (synchronous, active low) returns the decoder to plain mode and
//  empties the queue
// ----------------------------------------------------------------------------
module escape_sequence_decoder_unit import esd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    // raw byte channel
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // in_end
    // decoded result channel
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [0] has_byte, [1] run_last
    output logic       m_tlast    // string_done
);

    // input register
    logic       stage_valid_reg;
    logic [7:0] stage_byte_reg;
    logic       stage_end_reg;

    // decoder state
    esd_state_t state_reg;
    esd_state_t state_next;

    esd_result_t      res0;
    esd_result_t      res1;
    esd_result_t      head;
    logic [1:0]       res_n;
    logic [1:0]       push_n;
    esd_fifo_status_t fifo_status;
    logic             consume;
    logic             s_accept;

    // the staged byte is decoded once the queue can hold both its results
    assign consume  = stage_valid_reg && fifo_status.room;
    assign s_tready = !stage_valid_reg || fifo_status.room;
    assign s_accept = s_tvalid && s_tready;
    assign push_n   = consume ? res_n : 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (s_accept) begin
            stage_valid_reg <= 1'b1;
        end else if (consume) begin
            stage_valid_reg <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            stage_byte_reg <= s_tdata;
            stage_end_reg  <= s_tlast;
        end
    end

    // decoder state advances only when a byte is consumed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode        <= MODE_PLAIN;
            state_reg.digit_count <= 2'd0;
            state_reg.accum_value <= 8'd0;
        end else if (consume) begin
            state_reg <= state_next;
        end
    end

    esd_decode u_decode (
        .state_i (state_reg),
        .byte_i  (stage_byte_reg),
        .end_i   (stage_end_reg),
        .state_o (state_next),
        .res_n_o (res_n),
        .res0_o  (res0),
        .res1_o  (res1)
    );

    esd_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_n    (push_n),
        .push0     (res0),
        .push1     (res1),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_head  (head),
        .status    (fifo_status)
    );

    assign m_tdata    = head.out_byte;
    assign m_tuser[0] = head.has_byte;
    assign m_tuser[1] = head.run_last;
    assign m_tlast    = head.string_done;

    // queue never holds more than its depth
    a_fifo_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_status.level <= ESD_FIFO_CW'(ESD_FIFO_DEPTH))
        else $error("result queue over its depth");

    // an end byte always leaves at least one result
    a_end_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && stage_end_reg) |-> (res_n != 2'd0))
        else $error("end of string produced no result");

    // after the end of a string the decoder is back in plain mode
    a_end_plain: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && stage_end_reg) |=> (state_reg.mode == MODE_PLAIN))
        else $error("decoder not in plain mode after end of string");

endmodule
